// File: design/irpwd_pkg.sv
package irpwd_pkg;

  // default sizes
  localparam int DEF_CODE_BITS  = 12;
  localparam int DEF_WIDTH_BITS = 16;

  // bound register reset values, in prescaled clock units
  localparam int RST_START_MIN = 2250;
  localparam int RST_START_MAX = 2750;
  localparam int RST_ONE_MIN   = 1000;
  localparam int RST_ONE_MAX   = 1400;
  localparam int RST_BIT_MIN   = 300;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_MIN = 3'd0;
  localparam cfg_idx_t REG_START_MAX = 3'd1;
  localparam cfg_idx_t REG_ONE_MIN   = 3'd2;
  localparam cfg_idx_t REG_ONE_MAX   = 3'd3;
  localparam cfg_idx_t REG_BIT_MIN   = 3'd4;

  // verdict on one pulse width
  typedef struct packed {
    logic start_ok;  // inside the start window
    logic one_bit;   // strictly inside the one window
    logic bad;       // data pulse too narrow or too wide
  } pulse_class_t;

endpackage

// File: design/irpwd_classify.sv
module irpwd_classify import irpwd_pkg::*; #(
  parameter int WIDTH_BITS = DEF_WIDTH_BITS
) (
  input  logic [WIDTH_BITS-1:0] width,
  input  logic [WIDTH_BITS-1:0] start_min,
  input  logic [WIDTH_BITS-1:0] start_max,
  input  logic [WIDTH_BITS-1:0] one_min,
  input  logic [WIDTH_BITS-1:0] one_max,
  input  logic [WIDTH_BITS-1:0] bit_min,
  output pulse_class_t          verdict
);

  always_comb begin
    verdict.start_ok = (width >= start_min) && (width <= start_max);
    verdict.one_bit  = (width > one_min) && (width < one_max);
    // one-bit window wins over the error test when ranges overlap
    verdict.bad      = !verdict.one_bit && ((width < bit_min) || (width > one_max));
  end

endmodule

// File: design/ir_pulse_width_decoder.sv
// ir pulse-width decoder for 12-bit sirc-style frames. each input word is the
// measured width of one low pulse. while hunting, a pulse inside the start
// window (start_min..start_max, inclusive) opens a frame; the next CODE_BITS
// pulses are data bits, lsb first: a width strictly between one_min and
// one_max is a one, a width below bit_min or above one_max aborts the frame
// with a result word of code_word 0 and frame_error 1, anything else is a
// zero. after the last bit one result word carries the code with frame_error
// 0. start pulses and data bits that do not finish a frame give no result.
// throughput is one pulse word per clock unless a held result stalls it; a
// word is captured in the input register, classified and folded into the
// frame state by one compare stage, and any result lands in the output
// register when the word moves on. while a result word waits in the
// output register with out_ready low the input register holds, so in_ready
// drops once it is full. bound registers are written through the cfg port
// and must only change while no word is in flight.
module ir_pulse_width_decoder import irpwd_pkg::*; #(
  parameter int CODE_BITS  = DEF_CODE_BITS,
  parameter int WIDTH_BITS = DEF_WIDTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  cfg_idx_t              cfg_index,
  input  logic [WIDTH_BITS-1:0] cfg_data,
  // pulse width words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WIDTH_BITS-1:0] pulse_width,
  // decoded frame words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_BITS-1:0]  code_word,
  output logic                  frame_error
);

  localparam int IDX_BITS = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam logic [IDX_BITS-1:0] LAST_BIT = IDX_BITS'(CODE_BITS - 1);

  // bound registers
  logic [WIDTH_BITS-1:0] start_min;
  logic [WIDTH_BITS-1:0] start_max;
  logic [WIDTH_BITS-1:0] one_min;
  logic [WIDTH_BITS-1:0] one_max;
  logic [WIDTH_BITS-1:0] bit_min;

  // input stage
  logic                  in_full;
  logic [WIDTH_BITS-1:0] in_width;

  // frame state
  logic                  receiving;
  logic                  receiving_next;
  logic [IDX_BITS-1:0]   bit_index;
  logic [IDX_BITS-1:0]   bit_index_next;
  logic [CODE_BITS-1:0]  shift_code;
  logic [CODE_BITS-1:0]  shift_code_next;

  // result for the word in the input stage
  logic                  emit;
  logic [CODE_BITS-1:0]  emit_code;
  logic                  emit_error;

  logic                  advance;
  pulse_class_t          verdict;

  // cfg writes; indexes past the list fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      start_min <= WIDTH_BITS'(RST_START_MIN);
      start_max <= WIDTH_BITS'(RST_START_MAX);
      one_min   <= WIDTH_BITS'(RST_ONE_MIN);
      one_max   <= WIDTH_BITS'(RST_ONE_MAX);
      bit_min   <= WIDTH_BITS'(RST_BIT_MIN);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_MIN: start_min <= cfg_data;
        REG_START_MAX: start_max <= cfg_data;
        REG_ONE_MIN:   one_min   <= cfg_data;
        REG_ONE_MAX:   one_max   <= cfg_data;
        REG_BIT_MIN:   bit_min   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the input word moves on unless a result word is held with out_ready low
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_width <= pulse_width;
    end
  end

  irpwd_classify #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_classify (
    .width     (in_width),
    .start_min (start_min),
    .start_max (start_max),
    .one_min   (one_min),
    .one_max   (one_max),
    .bit_min   (bit_min),
    .verdict   (verdict)
  );

  // frame step for the word in the input stage
  always_comb begin
    receiving_next  = receiving;
    bit_index_next  = bit_index;
    shift_code_next = shift_code;
    emit            = 1'b0;
    emit_code       = '0;
    emit_error      = 1'b0;
    if (!receiving) begin
      // hunting: only a good start pulse opens a frame
      if (verdict.start_ok) begin
        receiving_next  = 1'b1;
        bit_index_next  = '0;
        shift_code_next = '0;
      end
    end else if (verdict.bad) begin
      // abort, report the error and go back to hunting
      receiving_next  = 1'b0;
      bit_index_next  = '0;
      shift_code_next = '0;
      emit            = 1'b1;
      emit_error      = 1'b1;
    end else begin
      if (verdict.one_bit) begin
        shift_code_next[bit_index] = 1'b1;
      end
      if (bit_index == LAST_BIT) begin
        // last data bit: hand out the code
        emit            = 1'b1;
        emit_code       = shift_code_next;
        receiving_next  = 1'b0;
        bit_index_next  = '0;
        shift_code_next = '0;
      end else begin
        bit_index_next = bit_index + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving  <= 1'b0;
      bit_index  <= '0;
      shift_code <= '0;
    end else if (advance) begin
      receiving  <= receiving_next;
      bit_index  <= bit_index_next;
      shift_code <= shift_code_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end
    end
    if (advance && emit) begin
      code_word   <= emit_code;
      frame_error <= emit_error;
    end
  end

endmodule
